// ===== src/rbst_pkg.sv =====
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRACTION_BITS = 16;

    // Exact difference magnitude, then scaled numerator for the division.
    localparam int MAG_W   = COORD_BITS + 1;
    localparam int NUM_W   = MAG_W + FRACTION_BITS;
    // Divider: one input stage, one stage per quotient bit, one saturation stage.
    localparam int DIV_LAT = NUM_W + 2;
    localparam int AXES    = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [NUM_W-1:0] POS_LIMIT =
        {{(NUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic [NUM_W-1:0] NEG_LIMIT =
        {{(NUM_W-COORD_BITS){1'b0}}, 1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } ray_box_t;

    typedef struct packed {
        logic   hit;
        coord_t distance;
    } hit_result_t;

    typedef struct packed {
        logic dir_zero;
        logic outside;
    } axis_flags_t;

    typedef struct packed {
        logic   miss;
        coord_t t_near;
        coord_t t_far;
    } interval_t;

endpackage

// ===== src/rbst_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage.
module rbst_div
    import rbst_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [MAG_W-1:0] num_mag,
    input  logic             num_neg,
    input  coord_t           den,
    output coord_t           quo
);

    logic [COORD_BITS-1:0] den_u;
    logic [COORD_BITS-1:0] den_mag;

    logic [NUM_W-1:0]      num_reg [0:NUM_W];
    logic [COORD_BITS-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0]      quo_reg [0:NUM_W];
    logic [COORD_BITS-1:0] dv_reg  [0:NUM_W];
    logic                  neg_reg [0:NUM_W];

    coord_t sat_next;
    coord_t sat_reg;

    assign den_u   = unsigned'(den);
    assign den_mag = den[COORD_BITS-1] ? (~den_u + {{(COORD_BITS-1){1'b0}}, 1'b1}) : den_u;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= {num_mag, {FRACTION_BITS{1'b0}}};
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            dv_reg[0]  <= den_mag;
            neg_reg[0] <= num_neg ^ den[COORD_BITS-1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_bit
            logic [COORD_BITS-1:0] trial;
            logic                  ge;

            assign trial = {rem_reg[k][COORD_BITS-2:0], num_reg[k][NUM_W-1]};
            assign ge    = (trial >= dv_reg[k]);

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[k+1] <= {num_reg[k][NUM_W-2:0], 1'b0};
                    rem_reg[k+1] <= ge ? (trial - dv_reg[k]) : trial;
                    quo_reg[k+1] <= {quo_reg[k][NUM_W-2:0], ge};
                    dv_reg[k+1]  <= dv_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                end
            end
        end
    endgenerate

    always_comb begin
        if (neg_reg[NUM_W]) begin
            if (quo_reg[NUM_W] > NEG_LIMIT) begin
                sat_next = COORD_MIN;
            end else begin
                sat_next = signed'(~quo_reg[NUM_W][COORD_BITS-1:0]
                                   + {{(COORD_BITS-1){1'b0}}, 1'b1});
            end
        end else begin
            if (quo_reg[NUM_W] > POS_LIMIT) begin
                sat_next = COORD_MAX;
            end else begin
                sat_next = signed'(quo_reg[NUM_W][COORD_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg <= sat_next;
        end
    end

    assign quo = sat_reg;

endmodule

// ===== src/rbst_merge.sv =====
// Axis-by-axis interval narrowing, one axis per pipeline stage.
module rbst_merge
    import rbst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   en,
    input  coord_t      [AXES-1:0] t_a,
    input  coord_t      [AXES-1:0] t_b,
    input  axis_flags_t [AXES-1:0] flags,
    output interval_t              res
);

    function automatic interval_t axis_step(interval_t cur, coord_t a, coord_t b,
                                            axis_flags_t f);
        interval_t nxt;
        coord_t    lo;
        coord_t    hi;
        nxt = cur;
        lo  = (a > b) ? b : a;
        hi  = (a > b) ? a : b;
        if (!cur.miss) begin
            if (f.dir_zero) begin
                nxt.miss = f.outside;
            end else begin
                nxt.t_near = (lo > cur.t_near) ? lo : cur.t_near;
                nxt.t_far  = (hi < cur.t_far) ? hi : cur.t_far;
                nxt.miss   = (nxt.t_near > nxt.t_far) || nxt.t_far[COORD_BITS-1];
            end
        end
        return nxt;
    endfunction

    interval_t              iv_reg    [0:AXES-1];
    coord_t      [AXES-1:0] ta_reg    [0:AXES-1];
    coord_t      [AXES-1:0] tb_reg    [0:AXES-1];
    axis_flags_t [AXES-1:0] flags_reg [0:AXES-1];
    interval_t              start_iv;

    assign start_iv = '{miss: 1'b0, t_near: COORD_MIN, t_far: COORD_MAX};

    always_ff @(posedge aclk) begin
        if (en) begin
            iv_reg[0]    <= axis_step(start_iv, t_a[0], t_b[0], flags[0]);
            ta_reg[0]    <= t_a;
            tb_reg[0]    <= t_b;
            flags_reg[0] <= flags;
        end
    end

    genvar k;
    generate
        for (k = 1; k < AXES; k++) begin : g_axis
            always_ff @(posedge aclk) begin
                if (en) begin
                    iv_reg[k]    <= axis_step(iv_reg[k-1], ta_reg[k-1][k],
                                              tb_reg[k-1][k], flags_reg[k-1][k]);
                    ta_reg[k]    <= ta_reg[k-1];
                    tb_reg[k]    <= tb_reg[k-1];
                    flags_reg[k] <= flags_reg[k-1];
                end
            end
        end
    endgenerate

    assign res = iv_reg[AXES-1];

endmodule

// ===== src/ray_box_slab_test_core.sv =====
// Top level of the streaming ray versus axis-aligned box slab test.
// Pipeline from an accepted input beat to its result beat: input register,
// 51-stage divider made of an input stage, 49 quotient-bit stages and a saturation
// stage, three axis stages, output register.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or its beat is being taken, so a stall freezes every stage in place.
module ray_box_slab_test_core
    import rbst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ray_box_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hit_result_t m_data
);

    // Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.

    // Valid chain: input register, divider stages, axis stages, output register.
    localparam int PIPE_DEPTH = 1 + DIV_LAT + AXES + 1;

    logic advance;
    logic vld_reg  [0:PIPE_DEPTH-1];
    logic vld_next [0:PIPE_DEPTH-1];

    ray_box_t in_reg;

    coord_t      [AXES-1:0] org;
    coord_t      [AXES-1:0] dir;
    coord_t      [AXES-1:0] bmin;
    coord_t      [AXES-1:0] bmax;
    axis_flags_t [AXES-1:0] flags_in;
    axis_flags_t [AXES-1:0] side_reg [0:DIV_LAT-1];
    coord_t      [AXES-1:0] t_max_side;
    coord_t      [AXES-1:0] t_min_side;

    interval_t   merged;
    hit_result_t out_next;
    hit_result_t out_reg;

    // The pipeline moves as a unit; an empty or draining output register lets it step.
    assign advance = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = advance;

    always_comb begin
        vld_next[0] = s_valid;
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg <= s_data;
        end
    end

    assign org  = {in_reg.origin_z, in_reg.origin_y, in_reg.origin_x};
    assign dir  = {in_reg.dir_z, in_reg.dir_y, in_reg.dir_x};
    assign bmin = {in_reg.box_min_z, in_reg.box_min_y, in_reg.box_min_x};
    assign bmax = {in_reg.box_max_z, in_reg.box_max_y, in_reg.box_max_x};

    // Per axis, the exact corner-minus-origin differences feed two dividers. A zero
    // direction component bypasses the division and only checks the slab bounds.
    genvar a;
    generate
        for (a = 0; a < AXES; a++) begin : g_axis
            logic signed [MAG_W-1:0] diff_hi;
            logic signed [MAG_W-1:0] diff_lo;
            logic        [MAG_W-1:0] mag_hi;
            logic        [MAG_W-1:0] mag_lo;

            assign diff_hi = MAG_W'(bmax[a]) - MAG_W'(org[a]);
            assign diff_lo = MAG_W'(bmin[a]) - MAG_W'(org[a]);
            assign mag_hi  = diff_hi[MAG_W-1] ? unsigned'(-diff_hi) : unsigned'(diff_hi);
            assign mag_lo  = diff_lo[MAG_W-1] ? unsigned'(-diff_lo) : unsigned'(diff_lo);

            assign flags_in[a].dir_zero = (dir[a] == '0);
            assign flags_in[a].outside  = (org[a] > bmax[a]) || (org[a] < bmin[a]);

            rbst_div u_div_hi (
                .aclk    (aclk),
                .en      (advance),
                .num_mag (mag_hi),
                .num_neg (diff_hi[MAG_W-1]),
                .den     (dir[a]),
                .quo     (t_max_side[a])
            );

            rbst_div u_div_lo (
                .aclk    (aclk),
                .en      (advance),
                .num_mag (mag_lo),
                .num_neg (diff_lo[MAG_W-1]),
                .den     (dir[a]),
                .quo     (t_min_side[a])
            );
        end
    endgenerate

    // The zero-direction flags ride alongside the divider array to stay aligned.
    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0] <= flags_in;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rbst_merge u_merge (
        .aclk  (aclk),
        .en    (advance),
        .t_a   (t_max_side),
        .t_b   (t_min_side),
        .flags (side_reg[DIV_LAT-1]),
        .res   (merged)
    );

    // A hit reports the entry distance when it lies ahead of the origin, otherwise the
    // exit distance; a miss reports zero.
    always_comb begin
        out_next.hit = !merged.miss;
        if (merged.miss) begin
            out_next.distance = '0;
        end else if (merged.t_near > 0) begin
            out_next.distance = merged.t_near;
        end else begin
            out_next.distance = merged.t_far;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[PIPE_DEPTH-1];
    assign m_data  = out_reg;

    // A hit never lies behind the ray, since the exit distance is checked against zero.
    a_hit_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |-> !m_data.distance[COORD_BITS-1])
        else $error("hit beat with negative distance");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.distance == '0))
        else $error("miss beat with nonzero distance");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

// ===== tb/ray_box_slab_checker.sv =====
// Checker for the ray versus box slab test: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module ray_box_slab_checker
    import rbst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  ray_box_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  hit_result_t m_data,
    output int          fail_count,
    output int          pending
);

    hit_result_t expected_hits[$];

    // Saturated (num * 2^FRACTION_BITS) / den, truncated toward zero.
    function automatic longint slab_distance(longint num, longint den);
        logic [127:0] mag;
        logic [127:0] dmag;
        logic [127:0] quo;
        logic         neg;
        begin
            neg  = (num < 0) != (den < 0);
            mag  = (num < 0) ? 128'(-num) : 128'(num);
            dmag = (den < 0) ? 128'(-den) : 128'(den);
            quo  = (mag << FRACTION_BITS) / dmag;
            if (neg) begin
                if (quo > 128'(64'h8000_0000)) return -64'sd2147483648;
                return -longint'(quo);
            end
            if (quo > 128'(64'h7fff_ffff)) return 64'sd2147483647;
            return longint'(quo);
        end
    endfunction

    function automatic hit_result_t slab_hit(ray_box_t rb);
        coord_t      org[3];
        coord_t      dir[3];
        coord_t      lo[3];
        coord_t      hi[3];
        longint      t_near;
        longint      t_far;
        longint      t1;
        longint      t2;
        longint      tmp;
        hit_result_t res;
        begin
            org = '{rb.origin_x, rb.origin_y, rb.origin_z};
            dir = '{rb.dir_x, rb.dir_y, rb.dir_z};
            lo  = '{rb.box_min_x, rb.box_min_y, rb.box_min_z};
            hi  = '{rb.box_max_x, rb.box_max_y, rb.box_max_z};
            t_near = COORD_MIN;
            t_far  = COORD_MAX;
            res    = '0;
            for (int a = 0; a < 3; a++) begin
                if (dir[a] != 0) begin
                    t1 = slab_distance(longint'(hi[a]) - longint'(org[a]), dir[a]);
                    t2 = slab_distance(longint'(lo[a]) - longint'(org[a]), dir[a]);
                    if (t1 > t2) begin
                        tmp = t1; t1 = t2; t2 = tmp;
                    end
                    if (t1 > t_near) t_near = t1;
                    if (t2 < t_far) t_far = t2;
                    if (t_near > t_far || t_far < 0) return res;
                end else if (org[a] > hi[a] || org[a] < lo[a]) begin
                    return res;
                end
            end
            res.hit      = 1'b1;
            res.distance = coord_t'((t_near > 0) ? t_near : t_far);
            return res;
        end
    endfunction

    always @(posedge aclk) begin
        hit_result_t want;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            expected_hits.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) expected_hits.push_back(slab_hit(s_data));
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result beat hit=%0b distance=%0d",
                           m_data.hit, m_data.distance);
                    errs++;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit !== m_data.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, m_data.hit);
                        errs++;
                    end
                    if (want.distance !== m_data.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, m_data.distance);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            pending <= expected_hits.size();
        end
    end

endmodule

// ===== tb/tb_ray_box_slab_test_core.sv =====
// Testbench top for the ray versus box slab test: stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module tb_ray_box_slab_test_core
    import rbst_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ray_box_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hit_result_t m_data;
    int          fail_count;
    int          pending;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always #4 aclk = ~aclk;

    ray_box_slab_test_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    ray_box_slab_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver draws a fresh ready every cycle from the current stall rate.
    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: counts cycles with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_ray_box_slab_test_core: errors");
                $finish;
            end
        end
    end

    function automatic coord_t any_coord();
        case ($urandom_range(5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Q16.16 value in a modest range so that most rays meet a slab in a sensible place.
    function automatic coord_t scene_coord(int span);
        return coord_t'($signed($urandom_range(2 * span)) - span) <<< FRACTION_BITS;
    endfunction

    // A well-formed box around a point, and a ray aimed roughly at it.
    function automatic ray_box_t aimed_ray();
        ray_box_t rb;
        coord_t   c[3];
        coord_t   o[3];
        coord_t   d[3];
        coord_t   h[3];
        begin
            for (int a = 0; a < 3; a++) begin
                c[a] = scene_coord(50) + coord_t'($urandom_range(65535));
                h[a] = coord_t'($urandom_range(20 << FRACTION_BITS));
                o[a] = scene_coord(100) + coord_t'($urandom_range(65535));
                d[a] = ($urandom_range(7) == 0) ? coord_t'(0)
                       : (c[a] - o[a]) + coord_t'($signed($urandom_range(8 << 16)) - (4 << 16));
                if ($urandom_range(3) == 0) d[a] = d[a] >>> $urandom_range(12);
            end
            rb.origin_x = o[0]; rb.origin_y = o[1]; rb.origin_z = o[2];
            rb.dir_x = d[0]; rb.dir_y = d[1]; rb.dir_z = d[2];
            rb.box_min_x = c[0] - h[0]; rb.box_min_y = c[1] - h[1]; rb.box_min_z = c[2] - h[2];
            rb.box_max_x = c[0] + h[0]; rb.box_max_y = c[1] + h[1]; rb.box_max_z = c[2] + h[2];
            // Occasionally invert the box on one axis.
            if ($urandom_range(15) == 0) begin
                rb.box_min_y = c[1] + h[1];
                rb.box_max_y = c[1] - h[1];
            end
            return rb;
        end
    endfunction

    function automatic ray_box_t noise_ray();
        ray_box_t rb;
        begin
            rb = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord()};
            return rb;
        end
    endfunction

    // Offers one beat, honoring the sender idle rate, and returns once it is accepted.
    // Valid stays high after the return so that back-to-back beats leave no gap.
    task automatic send_beat(ray_box_t rb);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_data  <= rb;
            s_valid <= 1'b1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
    endtask

    function automatic ray_box_t axis_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
        ray_box_t rb;
        begin
            // Ray along x with y and z origins inside unit slabs at zero direction.
            rb = '0;
            rb.origin_x = o; rb.dir_x = d; rb.box_min_x = lo; rb.box_max_x = hi;
            rb.box_min_y = -(1 << 16); rb.box_max_y = 1 << 16;
            rb.box_min_z = -(1 << 16); rb.box_max_z = 1 << 16;
            return rb;
        end
    endfunction

    initial begin
        ray_box_t rb;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: extremes, each special case, no idling.
        send_beat(axis_ray(0, 1 << 16, 2 << 16, 5 << 16));            // plain hit ahead
        send_beat(axis_ray(3 << 16, 1 << 16, 2 << 16, 5 << 16));      // origin inside box
        send_beat(axis_ray(9 << 16, 1 << 16, 2 << 16, 5 << 16));      // box behind ray
        send_beat(axis_ray(0, -(1 << 16), -(5 << 16), -(2 << 16)));   // negative direction
        send_beat(axis_ray(0, 1, 2 << 16, 5 << 16));                  // saturated quotients
        send_beat(axis_ray(0, -1, -(5 << 16), 5 << 16));              // negative saturation
        send_beat(axis_ray(0, 1 << 16, 5 << 16, 2 << 16));            // inverted box
        send_beat(axis_ray(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_beat(axis_ray(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_beat(axis_ray(COORD_MIN, 1, COORD_MAX, COORD_MAX));
        rb = axis_ray(0, 0, -(1 << 16), 1 << 16);                     // all directions zero
        send_beat(rb);
        rb.box_min_z = 1 << 16; rb.box_max_z = -(1 << 16);            // inverted, zero dir
        send_beat(rb);
        rb = axis_ray(0, 0, 1 << 16, 2 << 16);                        // outside zero-dir slab
        send_beat(rb);
        send_beat('1);
        send_beat({12{COORD_MIN}});
        send_beat({12{COORD_MAX}});
        rb = aimed_ray(); rb.dir_x = COORD_MIN; send_beat(rb);
        rb = aimed_ray(); rb.dir_z = COORD_MAX; send_beat(rb);

        // Random beats across the idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int i = 0; i < 100; i++)
                send_beat(($urandom_range(9) < 8) ? aimed_ray() : noise_ray());
        end
        s_valid <= 1'b0;

        recv_stall_pct = 0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) $display("tb_ray_box_slab_test_core: clean");
        else $display("tb_ray_box_slab_test_core: errors");
        $finish;
    end

endmodule
